### sv/salc_pkg.sv
// Shared types and constants of the set-associative LRU lookup unit.
// Used by salc_front, salc_back and the top level; no dependencies.
package salc_pkg;

    localparam logic [1:0] OUT_HIT   = 2'd0;
    localparam logic [1:0] OUT_COLD  = 2'd1;
    localparam logic [1:0] OUT_EVICT = 2'd2;

    localparam logic [1:0] CFG_INDEX_BITS  = 2'd0;
    localparam logic [1:0] CFG_OFFSET_BITS = 2'd1;
    localparam logic [1:0] CFG_WAYS_IN_USE = 2'd2;

    // Decoded access handed from front to back.
    typedef struct packed {
        logic [63:0] tag;
        logic [11:0] set;
        logic [4:0]  nways;
    } t_req;

endpackage

### sv/set_assoc_lru_cache_lookup_unit.sv
// Top level of the set-associative LRU tag lookup unit.
// Instantiates salc_front and salc_back; uses salc_pkg.
//
//  channel   direction  handshake                 payload
//  s_axis    in         s_axis_tvalid/tready      tdata[63:0] address
//  cfg       in         i_cfg_valid/o_cfg_ready   index[1:0], data[5:0]
//  m_axis    out        m_axis_tvalid/tready      tdata[1:0] outcome, [4:2] way_used
//
// Each access takes two steps in the back part: one to read the set row, one
// to resolve and write it back; this single row port sets the rate.
// After reset a clearing pass over all 2**MAX_SET_BITS sets runs; addresses queue
// in the front (two entries) but are not processed until it ends.
// A stalled result holds the back part; the front queue keeps accepting until full.
module set_assoc_lru_cache_lookup_unit #(
    parameter int MAX_SET_BITS = 6,
    parameter int WAYS         = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [63:0] address
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [5:0]  i_cfg_data,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // [1:0] outcome, [4:2] way_used, rest zero
);
    logic [2:0] r_index_bits;
    logic [5:0] r_offset_bits;
    logic [3:0] r_ways_in_use;
    logic       req_valid, req_ready;
    salc_pkg::t_req req;
    logic [1:0] outcome;
    logic [2:0] way_used;

    assign o_cfg_ready = 1'b1;

    // register writes; an index beyond the list is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index_bits  <= 3'd6;
            r_offset_bits <= 6'd4;
            r_ways_in_use <= 4'd8;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                salc_pkg::CFG_INDEX_BITS:  r_index_bits  <= i_cfg_data[2:0];
                salc_pkg::CFG_OFFSET_BITS: r_offset_bits <= i_cfg_data;
                salc_pkg::CFG_WAYS_IN_USE: r_ways_in_use <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    salc_front #(.MAX_SET_BITS(MAX_SET_BITS), .WAYS(WAYS)) u_front (
        .i_clk, .i_rst_n,
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready), .i_address(s_axis_tdata),
        .i_index_bits(r_index_bits), .i_offset_bits(r_offset_bits),
        .i_ways_in_use(r_ways_in_use),
        .o_req_valid(req_valid), .i_req_ready(req_ready), .o_req(req)
    );

    salc_back #(.MAX_SET_BITS(MAX_SET_BITS), .WAYS(WAYS)) u_back (
        .i_clk, .i_rst_n,
        .i_req_valid(req_valid), .o_req_ready(req_ready), .i_req(req),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_outcome(outcome), .o_way_used(way_used)
    );

    assign m_axis_tdata = {3'b000, way_used, outcome};
endmodule

### sv/salc_front.sv
// Front part: accepts addresses, splits them into set and tag and queues them.
// Depends on salc_pkg.
module salc_front #(
    parameter int MAX_SET_BITS = 6,
    parameter int WAYS         = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [63:0]       i_address,
    input  logic [2:0]        i_index_bits,
    input  logic [5:0]        i_offset_bits,
    input  logic [3:0]        i_ways_in_use,
    output logic              o_req_valid,
    input  logic              i_req_ready,
    output salc_pkg::t_req    o_req
);
    // two-entry queue
    salc_pkg::t_req r_q [2];
    logic [1:0] r_cnt, n_cnt;
    logic       r_rd, r_wr;
    logic [3:0] ib;
    logic [6:0] shift;
    logic [63:0] shifted;
    logic [4:0] nw;
    salc_pkg::t_req req;
    logic push, pop;

    always_comb begin
        ib = (32'(i_index_bits) > MAX_SET_BITS) ? 4'(MAX_SET_BITS) : {1'b0, i_index_bits};
        shifted = i_address >> i_offset_bits;
        shift = 7'(i_offset_bits) + 7'(ib);
        nw = (i_ways_in_use == 4'd0) ? 5'd1 : {1'b0, i_ways_in_use};
        if (32'(nw) > WAYS) nw = 5'(WAYS);
        req.set = 12'(shifted & ((64'd1 << ib) - 64'd1));
        req.tag = shift[6] ? 64'd0 : (i_address >> shift[5:0]);
        req.nways = nw;
    end

    assign o_ready     = (r_cnt != 2'd2);
    assign o_req_valid = (r_cnt != 2'd0);
    assign o_req       = r_q[r_rd];
    assign push        = i_valid && o_ready;
    assign pop         = o_req_valid && i_req_ready;

    always_comb begin
        n_cnt = r_cnt + 2'(push) - 2'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (push) r_wr <= ~r_wr;
            if (pop)  r_rd <= ~r_rd;
        end
        if (push) r_q[r_wr] <= req;
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count overflow");
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd2 |-> !o_ready) else $error("ready while full");
    a_empty_novalid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd0 |-> !o_req_valid) else $error("valid while empty");
endmodule

### sv/salc_back.sv
// Back part: reads a set, resolves hit / fill / eviction, ages and writes back.
// Depends on salc_pkg. Holds the tag, valid and age stores.
module salc_back #(
    parameter int MAX_SET_BITS = 6,
    parameter int WAYS         = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    input  salc_pkg::t_req    i_req,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [1:0]        o_outcome,
    output logic [2:0]        o_way_used
);
    localparam int SETS = 1 << MAX_SET_BITS;
    localparam int SB   = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int AW   = $clog2(WAYS) > 0 ? $clog2(WAYS) : 1;
    localparam int WB   = $clog2(WAYS + 1);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_EVAL  = 2'd2;

    // one memory row per set: all ways side by side
    logic [WAYS*64-1:0] mem_tag [SETS];
    logic [WAYS-1:0]    mem_vld [SETS];
    logic [WAYS*AW-1:0] mem_age [SETS];

    logic [WAYS*64-1:0] r_rtag;
    logic [WAYS-1:0]    r_rvld;
    logic [WAYS*AW-1:0] r_rage;
    logic [1:0]         r_st;
    logic [SB-1:0]      r_set, r_clr;
    logic [63:0]        r_tag;
    logic [WB-1:0]      r_nw;
    logic               r_ovld;
    logic [1:0]         r_out;
    logic [2:0]         r_way;

    logic [AW-1:0]      sel, limit;
    logic [1:0]         kind;
    logic               hit, fill;
    logic [WAYS*AW-1:0] new_age;
    logic [WAYS-1:0]    new_vld;
    logic [WAYS*64-1:0] new_tag;
    logic               start;

    assign o_req_ready = (r_st == ST_IDLE);
    assign start       = i_req_valid && o_req_ready;
    assign o_valid     = r_ovld;
    assign o_outcome   = r_out;
    assign o_way_used  = r_way;

    always_comb begin
        logic [AW-1:0] a, best;
        hit = 1'b0; fill = 1'b0; sel = '0; best = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (WB'(w) < r_nw && r_rvld[w] && r_rtag[w*64 +: 64] == r_tag) begin
                hit = 1'b1; sel = AW'(w);
            end
        end
        if (!hit) begin
            for (int w = WAYS - 1; w >= 0; w--) begin
                if (WB'(w) < r_nw && !r_rvld[w]) begin
                    fill = 1'b1; sel = AW'(w);
                end
            end
        end
        if (!hit && !fill) begin
            sel = '0; best = r_rage[AW-1:0];
            for (int w = 1; w < WAYS; w++) begin
                a = r_rage[w*AW +: AW];
                if (WB'(w) < r_nw && a > best) begin
                    best = a; sel = AW'(w);
                end
            end
        end
        kind  = hit ? salc_pkg::OUT_HIT : (fill ? salc_pkg::OUT_COLD : salc_pkg::OUT_EVICT);
        limit = r_rage[sel*AW +: AW];
        new_age = r_rage; new_vld = r_rvld; new_tag = r_rtag;
        for (int w = 0; w < WAYS; w++) begin
            a = r_rage[w*AW +: AW];
            if (WB'(w) < r_nw && AW'(w) != sel && r_rvld[w]
                && (fill || a < limit) && 32'(a) < WAYS - 1)
                new_age[w*AW +: AW] = a + AW'(1);
        end
        new_age[sel*AW +: AW] = '0;
        new_vld[sel] = 1'b1;
        new_tag[sel*64 +: 64] = r_tag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= ST_CLEAR;
            r_clr  <= '0;
            r_ovld <= 1'b0;
        end else begin
            if (r_st == ST_EVAL && (!r_ovld || i_ready)) r_ovld <= 1'b1;
            else if (i_ready) r_ovld <= 1'b0;
            unique case (r_st)
                ST_CLEAR: begin
                    if (r_clr == SB'(SETS - 1)) r_st <= ST_IDLE;
                    r_clr <= r_clr + SB'(1);
                end
                ST_IDLE: if (start) r_st <= ST_EVAL;
                ST_EVAL: if (!r_ovld || i_ready) r_st <= ST_IDLE;
                default: r_st <= ST_IDLE;
            endcase
        end
        if (start) begin
            r_set <= SB'(i_req.set);
            r_tag <= i_req.tag;
            r_nw  <= WB'(i_req.nways);
        end
        if (r_st == ST_EVAL && (!r_ovld || i_ready)) begin
            r_out <= kind;
            r_way <= 3'(sel);
        end
    end

    // memory: read on accept, write back on evaluation, valid and age cleared after reset
    always_ff @(posedge i_clk) begin
        if (start) begin
            r_rtag <= mem_tag[SB'(i_req.set)];
            r_rvld <= mem_vld[SB'(i_req.set)];
            r_rage <= mem_age[SB'(i_req.set)];
        end
        if (r_st == ST_CLEAR) begin
            mem_vld[r_clr] <= '0;
            mem_age[r_clr] <= '0;
        end else if (r_st == ST_EVAL && (!r_ovld || i_ready)) begin
            mem_vld[r_set] <= new_vld;
            mem_age[r_set] <= new_age;
            mem_tag[r_set] <= new_tag;
        end
    end

    a_eval_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == ST_EVAL && r_ovld && !i_ready |=> r_st == ST_EVAL)
        else $error("evaluation lost under stall");
    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == ST_CLEAR |-> !o_req_ready) else $error("accept during clear");
    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_outcome != 2'd3) else $error("bad outcome");
endmodule
